>>> rtl/core/pldd_pkg.sv
`timescale 1ns / 1ps

package pldd_pkg;

   localparam int COORD_BITS_DEF = 24;

   // diff, products, cross / A, partial squares, sum of squares
   localparam int FRONT_STAGES = 5;

   // signed cross product component
   function automatic int cross_w(input int cw);
      return 2 * cw + 2;
   endfunction

   // A = |V|^2
   function automatic int den_w(input int cw);
      return 2 * cw + 1;
   endfunction

   // D = |C|^2
   function automatic int num_w(input int cw);
      return 4 * cw + 3;
   endfunction

endpackage

>>> rtl/core/pldd_cross.sv
`timescale 1ns / 1ps

module pldd_cross import pldd_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic [2:0]                      en,
   input  logic signed [CW-1:0]            px,
   input  logic signed [CW-1:0]            py,
   input  logic signed [CW-1:0]            pz,
   input  logic signed [CW-1:0]            lx,
   input  logic signed [CW-1:0]            ly,
   input  logic signed [CW-1:0]            lz,
   input  logic signed [CW-1:0]            vx,
   input  logic signed [CW-1:0]            vy,
   input  logic signed [CW-1:0]            vz,
   output logic signed [cross_w(CW)-1:0]   c1,
   output logic signed [cross_w(CW)-1:0]   c2,
   output logic signed [cross_w(CW)-1:0]   c3,
   output logic [den_w(CW)-1:0]            a,
   output logic                            dz
);

   localparam int EW = CW + 1;
   localparam int PW = EW + CW;
   localparam int QW = 2 * CW;
   localparam int XW = cross_w(CW);
   localparam int AW = den_w(CW);

   // stage 1: difference vector L - P
   logic signed [EW-1:0] ex_ff, ey_ff, ez_ff;
   logic signed [CW-1:0] vx_ff, vy_ff, vz_ff;
   logic                 dz1_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ex_ff  <= EW'(lx) - EW'(px);
         ey_ff  <= EW'(ly) - EW'(py);
         ez_ff  <= EW'(lz) - EW'(pz);
         vx_ff  <= vx;
         vy_ff  <= vy;
         vz_ff  <= vz;
         dz1_ff <= (vx == '0) && (vy == '0) && (vz == '0);
      end
   end

   // stage 2: cross product terms and direction squares
   logic signed [PW-1:0] p_ff [6];
   logic signed [QW-1:0] s_ff [3];
   logic                 dz2_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ff[0] <= vy_ff * ez_ff;
         p_ff[1] <= vz_ff * ey_ff;
         p_ff[2] <= vz_ff * ex_ff;
         p_ff[3] <= vx_ff * ez_ff;
         p_ff[4] <= vx_ff * ey_ff;
         p_ff[5] <= vy_ff * ex_ff;
         s_ff[0] <= vx_ff * vx_ff;
         s_ff[1] <= vy_ff * vy_ff;
         s_ff[2] <= vz_ff * vz_ff;
         dz2_ff  <= dz1_ff;
      end
   end

   // stage 3: cross components and A
   logic signed [XW-1:0] c1_ff, c2_ff, c3_ff;
   logic [AW-1:0]        a_ff;
   logic                 dz3_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c1_ff  <= XW'(p_ff[0]) - XW'(p_ff[1]);
         c2_ff  <= XW'(p_ff[2]) - XW'(p_ff[3]);
         c3_ff  <= XW'(p_ff[4]) - XW'(p_ff[5]);
         // squares are never negative
         a_ff   <= AW'($unsigned(s_ff[0])) + AW'($unsigned(s_ff[1]))
                 + AW'($unsigned(s_ff[2]));
         dz3_ff <= dz2_ff;
      end
   end

   assign c1 = c1_ff;
   assign c2 = c2_ff;
   assign c3 = c3_ff;
   assign a  = a_ff;
   assign dz = dz3_ff;

endmodule

>>> rtl/core/pldd_sumsq.sv
`timescale 1ns / 1ps

module pldd_sumsq import pldd_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic [1:0]                      en,
   input  logic signed [cross_w(CW)-1:0]   c1,
   input  logic signed [cross_w(CW)-1:0]   c2,
   input  logic signed [cross_w(CW)-1:0]   c3,
   input  logic [den_w(CW)-1:0]            a_i,
   input  logic                            dz_i,
   output logic [num_w(CW)-1:0]            d,
   output logic [den_w(CW)-1:0]            a_o,
   output logic                            dz_o
);

   localparam int XW = cross_w(CW);
   localparam int MW = 2 * CW + 1;
   localparam int H  = CW + 1;
   localparam int HI = MW - H;
   localparam int AW = den_w(CW);
   localparam int DW = num_w(CW);

   logic signed [XW-1:0] c [3];
   logic [XW-1:0]        neg [3];
   logic [MW-1:0]        mag [3];

   assign c[0] = c1;
   assign c[1] = c2;
   assign c[2] = c3;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg[k] = -c[k];
         mag[k] = c[k][XW-1] ? neg[k][MW-1:0] : c[k][MW-1:0];
      end
   end

   // stage 4: magnitude split in halves, partial products
   logic [2*H-1:0]    ll_ff [3];
   logic [H+HI-1:0]   hl_ff [3];
   logic [2*HI-1:0]   hh_ff [3];
   logic [AW-1:0]     a4_ff;
   logic              dz4_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 3; k++) begin
            ll_ff[k] <= mag[k][H-1:0] * mag[k][H-1:0];
            hl_ff[k] <= mag[k][MW-1:H] * mag[k][H-1:0];
            hh_ff[k] <= mag[k][MW-1:H] * mag[k][MW-1:H];
         end
         a4_ff  <= a_i;
         dz4_ff <= dz_i;
      end
   end

   // stage 5: D = sum of the three squares
   logic [DW-1:0] sq [3];
   logic [DW-1:0] d_ff;
   logic [AW-1:0] a5_ff;
   logic          dz5_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq[k] = (DW'(hh_ff[k]) << (2 * H)) + (DW'(hl_ff[k]) << (H + 1)) + DW'(ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         d_ff   <= sq[0] + sq[1] + sq[2];
         a5_ff  <= a4_ff;
         dz5_ff <= dz4_ff;
      end
   end

   assign d    = d_ff;
   assign a_o  = a5_ff;
   assign dz_o = dz5_ff;

endmodule

>>> rtl/core/pldd_root.sv
`timescale 1ns / 1ps

module pldd_root import pldd_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic [CW:0]              en,
   input  logic [num_w(CW)-1:0]     d,
   input  logic [den_w(CW)-1:0]     a,
   input  logic                     dz_i,
   output logic [CW:0]              r,
   output logic                     dz_o
);

   localparam int NR = CW + 1;
   localparam int DW = num_w(CW);
   localparam int AW = den_w(CW);
   localparam int RW = 3 * CW + 2;
   localparam int XW = 4 * CW + 5;

   // per stage: T = r*r*A, RA = r*A, partial root r
   logic [DW-1:0] t_ff  [NR];
   logic [RW-1:0] ra_ff [NR];
   logic [CW:0]   r_ff  [NR];
   logic [DW-1:0] d_ff  [NR];
   logic [AW-1:0] a_ff  [NR];
   logic          dz_ff [NR];

   for (genvar k = 0; k < NR; k++) begin : g_bit
      localparam int B = CW - k;

      logic [DW-1:0] t_prev;
      logic [RW-1:0] ra_prev;
      logic [CW:0]   r_prev;
      logic [DW-1:0] d_prev;
      logic [AW-1:0] a_prev;
      logic          dz_prev;
      logic [XW-1:0] cand;
      logic          take;

      if (k == 0) begin : g_first
         assign t_prev  = '0;
         assign ra_prev = '0;
         assign r_prev  = '0;
         assign d_prev  = d;
         assign a_prev  = a;
         assign dz_prev = dz_i;
      end else begin : g_next
         assign t_prev  = t_ff[k-1];
         assign ra_prev = ra_ff[k-1];
         assign r_prev  = r_ff[k-1];
         assign d_prev  = d_ff[k-1];
         assign a_prev  = a_ff[k-1];
         assign dz_prev = dz_ff[k-1];
      end

      // (r + 2^B)^2 * A = T + 2^(B+1) * RA + 2^(2B) * A
      assign cand = XW'(t_prev) + (XW'(ra_prev) << (B + 1)) + (XW'(a_prev) << (2 * B));
      assign take = cand <= XW'(d_prev);

      always_ff @(posedge clock) begin
         if (en[k]) begin
            t_ff[k]  <= take ? cand[DW-1:0] : t_prev;
            ra_ff[k] <= take ? ra_prev + (RW'(a_prev) << B) : ra_prev;
            r_ff[k]  <= take ? (r_prev | ((CW + 1)'(1) << B)) : r_prev;
            d_ff[k]  <= d_prev;
            a_ff[k]  <= a_prev;
            dz_ff[k] <= dz_prev;
         end
      end
   end

   assign r    = r_ff[NR-1];
   assign dz_o = dz_ff[NR-1];

endmodule

>>> rtl/core/point_to_line_distance_3d.sv
`timescale 1ns / 1ps
// point_to_line_distance_3d: floor of the distance from a query point to a line,
// signed fixed point coordinates in, unsigned distance of the same format out.
// input channel req_*: query point, a point on the line and the line direction,
// one transfer per item. result channel rsp_*: distance and dir_zero, one
// transfer per item, in input order. a zero direction gives distance 0 and
// dir_zero high.
// from input transfer to rsp_valid an item passes five stages of difference,
// products, cross/A, partial squares and sum, then one stage per result bit of
// the bit-by-bit root search.
// throughput is one item per clock; every stage holds a valid bit, so req_ready
// stays high while any stage ahead is empty and bubbles close up under a stall.
// when rsp_ready is low with a result waiting, the pipe keeps filling until it is
// full, and only then does req_ready drop; nothing is lost or repeated.
// synchronous reset clears the valid bits only; the datapath registers are not reset.
module point_to_line_distance_3d import pldd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   input  logic signed [COORD_BITS-1:0]  req_line_x,
   input  logic signed [COORD_BITS-1:0]  req_line_y,
   input  logic signed [COORD_BITS-1:0]  req_line_z,
   input  logic signed [COORD_BITS-1:0]  req_dir_x,
   input  logic signed [COORD_BITS-1:0]  req_dir_y,
   input  logic signed [COORD_BITS-1:0]  req_dir_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS:0]           rsp_distance,
   output logic                          rsp_dir_zero
);

   localparam int CW = COORD_BITS;
   localparam int NS = FRONT_STAGES + CW + 1;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   // a stage loads when it is empty or the stage after it moves
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   logic signed [cross_w(CW)-1:0] c1, c2, c3;
   logic [den_w(CW)-1:0]          a3, a5;
   logic [num_w(CW)-1:0]          d5;
   logic                          dz3, dz5, dz_out;
   logic [CW:0]                   root;

   pldd_cross #(.CW(CW)) u_cross (
      .clock (clock),
      .en    (en[2:0]),
      .px    (req_point_x),
      .py    (req_point_y),
      .pz    (req_point_z),
      .lx    (req_line_x),
      .ly    (req_line_y),
      .lz    (req_line_z),
      .vx    (req_dir_x),
      .vy    (req_dir_y),
      .vz    (req_dir_z),
      .c1    (c1),
      .c2    (c2),
      .c3    (c3),
      .a     (a3),
      .dz    (dz3)
   );

   pldd_sumsq #(.CW(CW)) u_sumsq (
      .clock (clock),
      .en    (en[4:3]),
      .c1    (c1),
      .c2    (c2),
      .c3    (c3),
      .a_i   (a3),
      .dz_i  (dz3),
      .d     (d5),
      .a_o   (a5),
      .dz_o  (dz5)
   );

   pldd_root #(.CW(CW)) u_root (
      .clock (clock),
      .en    (en[NS-1:FRONT_STAGES]),
      .d     (d5),
      .a     (a5),
      .dz_i  (dz5),
      .r     (root),
      .dz_o  (dz_out)
   );

   assign req_ready    = en[0];
   assign rsp_valid    = vld_ff[NS-1];
   // a zero direction makes A zero and the search saturates, so mask it
   assign rsp_distance = dz_out ? '0 : root;
   assign rsp_dir_zero = dz_out;

   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dir_zero |-> rsp_distance == '0)
      else $error("zero direction with nonzero distance");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer lost at first stage");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import pldd_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LATENCY = CB + 6;

   typedef logic signed [CB-1:0] coord_t;

   typedef struct packed {
      coord_t px, py, pz;
      coord_t lx, ly, lz;
      coord_t vx, vy, vz;
   } query_t;

   typedef struct packed {
      logic [CB:0] distance;
      logic        zero;
   } answer_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_t req_point_x = '0, req_point_y = '0, req_point_z = '0;
   coord_t req_line_x = '0, req_line_y = '0, req_line_z = '0;
   coord_t req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CB:0] rsp_distance;
   logic rsp_dir_zero;

   answer_t expected_q[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit no_gaps = 0;
   bit hold_toggle = 0;
   bit hold_seen = 0;
   int hold_left = 0;
   int rx_gap = 0;

   always #5 clock = ~clock;

   point_to_line_distance_3d u_top (.*);

   // exact distance floor: largest r with r*r*A <= D
   function automatic answer_t line_distance(query_t q);
      logic signed [127:0] vx, vy, vz, ex, ey, ez, c1, c2, c3;
      logic [127:0] num, den, cand, t;
      logic [CB:0] r;
      answer_t a;
      vx = q.vx; vy = q.vy; vz = q.vz;
      ex = 128'(signed'(q.lx)) - 128'(signed'(q.px));
      ey = 128'(signed'(q.ly)) - 128'(signed'(q.py));
      ez = 128'(signed'(q.lz)) - 128'(signed'(q.pz));
      r = '0;
      if (q.vx == 0 && q.vy == 0 && q.vz == 0) begin
         a.distance = '0;
         a.zero = 1'b1;
         return a;
      end
      c1 = vy * ez - vz * ey;
      c2 = vz * ex - vx * ez;
      c3 = vx * ey - vy * ex;
      num = c1 * c1 + c2 * c2 + c3 * c3;
      den = vx * vx + vy * vy + vz * vz;
      for (int b = CB; b >= 0; b--) begin
         cand = r | (128'd1 << b);
         t = cand * cand * den;
         if (t <= num) r = cand[CB:0];
      end
      a.distance = r;
      a.zero = 1'b0;
      return a;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_query(query_t q, bit gaps = 1);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_point_x, req_point_y, req_point_z, req_line_x, req_line_y, req_line_z,
       req_dir_x, req_dir_y, req_dir_z} <= q;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(line_distance(q));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic coord_t rand_coord();
      int m;
      m = $urandom_range(0, 9);
      if (m < 5) return coord_t'($urandom);
      if (m < 7) return coord_t'($urandom_range(0, 255) - 128);
      if (m < 8) return coord_t'(0);
      if (m < 9) return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      return coord_t'($urandom_range(0, 1) ? 4096 : -4096);
   endfunction

   function automatic query_t rand_query();
      query_t q;
      int m;
      q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      m = $urandom_range(0, 19);
      if (m == 0) {q.vx, q.vy, q.vz} = '0;
      else if (m == 1) {q.px, q.py, q.pz} = {q.lx, q.ly, q.lz};
      else if (m == 2) {q.vy, q.vz} = '0;
      return q;
   endfunction

   task automatic test_directed();
      coord_t mx, mn;
      query_t q;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      send_query({mx, mx, mx, mx, mx, mx, mx, mx, mx});
      send_query({mn, mn, mn, mn, mn, mn, mn, mn, mn});
      send_query({mx, mx, mx, mn, mn, mn, mx, mn, mx});
      send_query({mn, mn, mn, mx, mx, mx, mn, mx, mn});
      send_query({mn, mx, mn, mx, mn, mx, mn, mn, mn});
      send_query({mx, mn, mx, mn, mx, mn, coord_t'(1), coord_t'(0), coord_t'(0)});
      // zero direction, with and without an offset point
      send_query({mx, mn, mx, mn, mx, mn, coord_t'(0), coord_t'(0), coord_t'(0)});
      send_query({9'(0), 207'(0)});
      send_query({mx, mx, mx, mn, mn, mn, coord_t'(0), coord_t'(0), coord_t'(0)});
      // point on the line
      send_query({coord_t'(100), coord_t'(-5), coord_t'(7), coord_t'(100), coord_t'(-5),
                  coord_t'(7), coord_t'(4096), coord_t'(-3), coord_t'(2)});
      // unit axes, exact distances
      send_query({coord_t'(0), coord_t'(12288), coord_t'(0), coord_t'(0), coord_t'(0),
                  coord_t'(0), coord_t'(4096), coord_t'(0), coord_t'(0)});
      send_query({coord_t'(4096), coord_t'(0), coord_t'(4096), coord_t'(0), coord_t'(0),
                  coord_t'(0), coord_t'(0), coord_t'(4096), coord_t'(0)});
      send_query({coord_t'(3), coord_t'(4), coord_t'(0), coord_t'(0), coord_t'(0),
                  coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(-1)});
      send_query({mn, mn, mx, mx, mx, mn, coord_t'(0), coord_t'(0), coord_t'(1)});
      send_query({mn, mn, mn, mx, mx, mx, coord_t'(-1), coord_t'(-1), coord_t'(-1)});
      q = {coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(1),
           coord_t'(1), mn, coord_t'(0), coord_t'(0)};
      send_query(q);
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_query(rand_query());
      end
      no_gaps = 0;
   endtask

   // receiver holds off while the sender keeps offering, filling the pipe
   task automatic test_backpressure();
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 100; i++) send_query(rand_query(), 0);
   endtask

   task automatic test_pause_and_resume();
      wait_drained();
      test_random(50);
   endtask

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= (rx_gap == 1);
      end else if (!reset && rsp_ready && pick_gap() > 0) begin
         rx_gap <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset;
      end
   end

   always @(posedge clock) begin
      answer_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: distance %0d dir_zero %0b",
                        rsp_distance, rsp_dir_zero);
         end else begin
            want = expected_q.pop_front();
            if (rsp_distance !== want.distance || rsp_dir_zero !== want.zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: distance exp %0d got %0d, dir_zero exp %0b got %0b",
                           want.distance, rsp_distance, want.zero, rsp_dir_zero);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(900);
      test_backpressure();
      test_pause_and_resume();
      test_random(900);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pldd_pkg.sv
rtl/core/pldd_cross.sv
rtl/core/pldd_sumsq.sv
rtl/core/pldd_root.sv
rtl/core/point_to_line_distance_3d.sv
tb/sv/tb.sv
